// ===== design/etf_pkg.sv =====
// ----------------------------------------------------------------------------
// Escape-time fractal pixel: shared package
// Widths, fixed-point constants, register indexes, sequencer states,
// multiplier request/response structs and the saturation helper.
// ----------------------------------------------------------------------------
package etf_pkg;

	// Image and number format
	localparam int IMG_W     = 1024;
	localparam int IMG_H     = 1024;
	localparam int FRAC_BITS = 44;
	localparam int PIX_W     = 10;
	localparam int ITER_W    = 12;
	localparam int VAL_W     = 48;
	localparam int STEP_W    = 47;
	localparam int PROD_W    = 2 * VAL_W;
	localparam int SQ_W      = PROD_W - FRAC_BITS;
	localparam int MAP_W     = 60;
	localparam int SUM_W     = 56;
	localparam int CFG_IDX_W = 3;

	// Register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODE      = 3'd0,
		REG_MAX_ITER  = 3'd1,
		REG_STEP      = 3'd2,
		REG_CENTER_RE = 3'd3,
		REG_CENTER_IM = 3'd4,
		REG_JULIA_RE  = 3'd5,
		REG_JULIA_IM  = 3'd6,
		REG_BAILOUT   = 3'd7
	} cfg_reg_t;

	// Fractal modes; the unused code behaves as Mandelbrot
	localparam logic [1:0] MODE_MANDEL = 2'd0;
	localparam logic [1:0] MODE_JULIA  = 2'd1;
	localparam logic [1:0] MODE_SHIP   = 2'd2;

	// Reset values
	localparam logic [1:0]        RST_MODE     = MODE_MANDEL;
	localparam logic [ITER_W-1:0] RST_MAX_ITER = 12'd50;
	localparam logic [STEP_W-1:0] RST_STEP     = 47'd117281240296;
	localparam logic [STEP_W-1:0] RST_BAILOUT  = 47'd70368744177664;

	// Sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MAP_RE,
		ST_MAP_IM,
		ST_CHECK,
		ST_SQ_RE,
		ST_SQ_IM,
		ST_CROSS,
		ST_UPDATE,
		ST_FINISH
	} state_t;

	// Shared multiplier interface
	typedef struct packed {
		logic             start;
		logic [VAL_W-1:0] a;
		logic [VAL_W-1:0] b;
	} mul_req_t;

	typedef struct packed {
		logic              busy;
		logic              done;
		logic [PROD_W-1:0] prod;
	} mul_rsp_t;

	localparam logic signed [63:0] VAL_MAX64 = (64'sd1 <<< (VAL_W - 1)) - 64'sd1;
	localparam logic signed [63:0] VAL_MIN64 = -(64'sd1 <<< (VAL_W - 1));

	// Clamp a wide signed value into the plane range
	function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [63:0] v);
		logic signed [VAL_W-1:0] r;
		if (v > VAL_MAX64) begin
			r = VAL_MAX64[VAL_W-1:0];
		end else if (v < VAL_MIN64) begin
			r = VAL_MIN64[VAL_W-1:0];
		end else begin
			r = v[VAL_W-1:0];
		end
		return r;
	endfunction

	// Magnitude of a plane value (the most negative value maps to 2^47)
	function automatic logic [VAL_W-1:0] mag_val(input logic [VAL_W-1:0] v);
		logic [VAL_W-1:0] r;
		r = v[VAL_W-1] ? (~v + 1'b1) : v;
		return r;
	endfunction

endpackage

// ===== design/etf_intf.sv =====
// ----------------------------------------------------------------------------
// Escape-time fractal pixel: channel interfaces
// Pixel input, result output and register write channels, valid/ready.
// ----------------------------------------------------------------------------
interface etf_pix_if;
	import etf_pkg::*;
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel_x;
	logic [PIX_W-1:0] pixel_y;

	modport source (output valid, pixel_x, pixel_y, input ready);
	modport sink   (input valid, pixel_x, pixel_y, output ready);
endinterface

interface etf_res_if;
	import etf_pkg::*;
	logic              valid;
	logic              ready;
	logic [PIX_W-1:0]  out_x;
	logic [PIX_W-1:0]  out_y;
	logic [ITER_W-1:0] iter_count;
	logic              escaped;

	modport source (output valid, out_x, out_y, iter_count, escaped, input ready);
	modport sink   (input valid, out_x, out_y, iter_count, escaped, output ready);
endinterface

interface etf_cfg_if;
	import etf_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [VAL_W-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/etf_mul.sv =====
// ----------------------------------------------------------------------------
// Escape-time fractal pixel: shared multiplier
// 48x48 unsigned product built from four 24x24 partial products, one per
// cycle, registered and accumulated. Done pulses once the product is complete.
// ----------------------------------------------------------------------------
module etf_mul (
	input  logic              clk,
	input  logic              arst_n,
	input  etf_pkg::mul_req_t req,
	output etf_pkg::mul_rsp_t rsp
);
	import etf_pkg::*;

	localparam int HALF_W = VAL_W / 2;
	localparam logic [1:0] SH_0  = 2'd0;
	localparam logic [1:0] SH_H  = 2'd1;
	localparam logic [1:0] SH_F  = 2'd2;
	localparam logic [1:0] CNT_LAST = 2'd3;

	logic [VAL_W-1:0]    a_q, b_q;
	logic [1:0]          cnt_q;
	logic                issue_q;
	logic                vld_s1, last_s1;
	logic [1:0]          sh_s1;
	logic [VAL_W-1:0]    pp_s1;
	logic [PROD_W-1:0]   acc_q;
	logic                done_q;
	logic [HALF_W-1:0]   a_part, b_part;
	logic [1:0]          sh_code;
	logic [PROD_W-1:0]   pp_ext;

	// Operand halves for the current partial product
	assign a_part  = cnt_q[1] ? a_q[VAL_W-1:HALF_W] : a_q[HALF_W-1:0];
	assign b_part  = cnt_q[0] ? b_q[VAL_W-1:HALF_W] : b_q[HALF_W-1:0];
	assign sh_code = 2'({1'b0, cnt_q[1]} + {1'b0, cnt_q[0]});

	// Place the registered partial product
	always_comb begin
		case (sh_s1)
			SH_0:    pp_ext = {{(PROD_W-VAL_W){1'b0}}, pp_s1};
			SH_H:    pp_ext = {{HALF_W{1'b0}}, pp_s1, {HALF_W{1'b0}}};
			SH_F:    pp_ext = {pp_s1, {VAL_W{1'b0}}};
			default: pp_ext = {{(PROD_W-VAL_W){1'b0}}, pp_s1};
		endcase
	end

	// Issue control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_q <= 1'b0;
			cnt_q   <= 2'd0;
			vld_s1  <= 1'b0;
			last_s1 <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			if (req.start) begin
				issue_q <= 1'b1;
				cnt_q   <= 2'd0;
			end else if (issue_q) begin
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == CNT_LAST) begin
					issue_q <= 1'b0;
				end
			end
			vld_s1  <= issue_q;
			last_s1 <= issue_q && (cnt_q == CNT_LAST);
			done_q  <= vld_s1 && last_s1;
		end
	end

	// Operands, partial product and accumulator
	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q   <= req.a;
			b_q   <= req.b;
			acc_q <= '0;
		end else if (vld_s1) begin
			acc_q <= acc_q + pp_ext;
		end
		pp_s1 <= a_part * b_part;
		sh_s1 <= sh_code;
	end

	assign rsp.busy = issue_q || vld_s1;
	assign rsp.done = done_q;
	assign rsp.prod = acc_q;

endmodule

// ===== design/escape_time_fractal_pixel.sv =====
// ----------------------------------------------------------------------------
// Escape-time fractal pixel engine
// An item is mapped to the plane, then iterated until the point escapes or the
// iteration limit is reached. One item at a time; each iteration runs three
// 48x48 products through the single 24x24 multiplier, plus a check and an
// update state; an escaping iteration stops after the two squares.
// Reset: asynchronous, active low; registers return to their default values.
// ----------------------------------------------------------------------------
module escape_time_fractal_pixel (
	input logic        clk,
	input logic        arst_n,
	etf_pix_if.sink    pix_in,
	etf_res_if.source  res_out,
	etf_cfg_if.sink    cfg
);
	import etf_pkg::*;

	localparam logic [PIX_W:0] HALF_X = (PIX_W+1)'(IMG_W / 2);
	localparam logic [PIX_W:0] HALF_Y = (PIX_W+1)'(IMG_H / 2);

	// Configuration registers
	logic [1:0]              mode_q;
	logic [ITER_W-1:0]       max_iter_q;
	logic [STEP_W-1:0]       step_q;
	logic [VAL_W-1:0]        center_re_q, center_im_q;
	logic [VAL_W-1:0]        julia_re_q, julia_im_q;
	logic [STEP_W-1:0]       bailout_q;

	// Sequencer and working registers
	state_t                  state_q, state_d;
	logic                    run_q;
	logic [PIX_W-1:0]        px_q, py_q;
	logic [VAL_W-1:0]        re_q, im_q, c_re_q, c_im_q;
	logic [SQ_W-1:0]         sr_q, si_q, cross_q;
	logic [ITER_W-1:0]       j_q, count_q;
	logic                    esc_q;

	// Result register
	logic                    out_valid_q;
	logic [PIX_W-1:0]        out_x_q, out_y_q;
	logic [ITER_W-1:0]       out_cnt_q;
	logic                    out_esc_q;

	mul_req_t                mul_req;
	mul_rsp_t                mul_rsp;

	logic [PIX_W:0]          ox, oy, o_sel, o_mag;
	logic                    map_neg;
	logic signed [MAP_W-1:0] map_prod, map_off, map_sum;
	logic [VAL_W-1:0]        p_val;
	logic [SQ_W-1:0]         sq;
	logic                    escape;
	logic                    cross_neg;
	logic signed [SUM_W-1:0] upd_re_sum, upd_im_sum, cross2;
	logic [VAL_W-1:0]        upd_re, upd_im;
	logic                    mul_state;
	logic                    load_out;

	etf_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	// Register writes
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= RST_MODE;
			max_iter_q  <= RST_MAX_ITER;
			step_q      <= RST_STEP;
			center_re_q <= '0;
			center_im_q <= '0;
			julia_re_q  <= '0;
			julia_im_q  <= '0;
			bailout_q   <= RST_BAILOUT;
		end else if (cfg.valid) begin
			case (cfg_reg_t'(cfg.index))
				REG_MODE:      mode_q      <= cfg.data[1:0];
				REG_MAX_ITER:  max_iter_q  <= cfg.data[ITER_W-1:0];
				REG_STEP:      step_q      <= cfg.data[STEP_W-1:0];
				REG_CENTER_RE: center_re_q <= cfg.data;
				REG_CENTER_IM: center_im_q <= cfg.data;
				REG_JULIA_RE:  julia_re_q  <= cfg.data;
				REG_JULIA_IM:  julia_im_q  <= cfg.data;
				REG_BAILOUT:   bailout_q   <= cfg.data[STEP_W-1:0];
				default:       mode_q      <= mode_q;
			endcase
		end
	end

	// Pixel offset from the image centre and its magnitude
	assign ox      = {1'b0, px_q} - HALF_X;
	assign oy      = {1'b0, py_q} - HALF_Y;
	assign o_sel   = (state_q == ST_MAP_IM) ? oy : ox;
	assign o_mag   = o_sel[PIX_W] ? (~o_sel + 1'b1) : o_sel;
	assign map_neg = o_sel[PIX_W];

	// Mapped coordinate: signed product plus centre re, or minus centre im
	assign map_prod = map_neg ? -$signed(mul_rsp.prod[MAP_W-1:0])
	                          : $signed(mul_rsp.prod[MAP_W-1:0]);
	assign map_off  = (state_q == ST_MAP_IM)
		? -$signed({{(MAP_W-VAL_W){center_im_q[VAL_W-1]}}, center_im_q})
		:  $signed({{(MAP_W-VAL_W){center_re_q[VAL_W-1]}}, center_re_q});
	assign map_sum  = map_prod + map_off;
	assign p_val    = sat_val({{(64-MAP_W){map_sum[MAP_W-1]}}, map_sum});

	// Truncated square or cross magnitude, and the escape test
	assign sq     = mul_rsp.prod[PROD_W-1:FRAC_BITS];
	assign escape = ({1'b0, sr_q} + {1'b0, sq}) > {{(SQ_W+1-STEP_W){1'b0}}, bailout_q};

	// New z: burning ship folds both parts positive, so the cross term is too
	assign cross_neg  = (mode_q != MODE_SHIP) && (re_q[VAL_W-1] ^ im_q[VAL_W-1]);
	assign cross2     = cross_neg ? -$signed({{(SUM_W-SQ_W-1){1'b0}}, cross_q, 1'b0})
	                              :  $signed({{(SUM_W-SQ_W-1){1'b0}}, cross_q, 1'b0});
	assign upd_re_sum = $signed({{(SUM_W-SQ_W){1'b0}}, sr_q})
	                  - $signed({{(SUM_W-SQ_W){1'b0}}, si_q})
	                  + $signed({{(SUM_W-VAL_W){c_re_q[VAL_W-1]}}, c_re_q});
	assign upd_im_sum = cross2 + $signed({{(SUM_W-VAL_W){c_im_q[VAL_W-1]}}, c_im_q});
	assign upd_re     = sat_val({{(64-SUM_W){upd_re_sum[SUM_W-1]}}, upd_re_sum});
	assign upd_im     = sat_val({{(64-SUM_W){upd_im_sum[SUM_W-1]}}, upd_im_sum});

	assign load_out = (state_q == ST_FINISH) && (!out_valid_q || res_out.ready);

	// Next state and multiplier operands
	always_comb begin
		state_d     = state_q;
		mul_state   = 1'b0;
		mul_req.a   = '0;
		mul_req.b   = '0;
		case (state_q)
			ST_IDLE: begin
				if (pix_in.valid) begin
					state_d = ST_MAP_RE;
				end
			end
			ST_MAP_RE, ST_MAP_IM: begin
				mul_state = 1'b1;
				mul_req.a = {{(VAL_W-PIX_W-1){1'b0}}, o_mag};
				mul_req.b = {{(VAL_W-STEP_W){1'b0}}, step_q};
				if (mul_rsp.done) begin
					state_d = (state_q == ST_MAP_RE) ? ST_MAP_IM : ST_CHECK;
				end
			end
			ST_CHECK: begin
				state_d = (j_q == max_iter_q) ? ST_FINISH : ST_SQ_RE;
			end
			ST_SQ_RE: begin
				mul_state = 1'b1;
				mul_req.a = mag_val(re_q);
				mul_req.b = mag_val(re_q);
				if (mul_rsp.done) begin
					state_d = ST_SQ_IM;
				end
			end
			ST_SQ_IM: begin
				mul_state = 1'b1;
				mul_req.a = mag_val(im_q);
				mul_req.b = mag_val(im_q);
				if (mul_rsp.done) begin
					state_d = escape ? ST_FINISH : ST_CROSS;
				end
			end
			ST_CROSS: begin
				mul_state = 1'b1;
				mul_req.a = mag_val(re_q);
				mul_req.b = mag_val(im_q);
				if (mul_rsp.done) begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				state_d = ST_CHECK;
			end
			ST_FINISH: begin
				if (load_out) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
		mul_req.start = mul_state && !run_q;
	end

	assign pix_in.ready = (state_q == ST_IDLE);

	// Sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			run_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (mul_req.start) begin
				run_q <= 1'b1;
			end else if (mul_rsp.done) begin
				run_q <= 1'b0;
			end
		end
	end

	// Working values
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				px_q <= pix_in.pixel_x;
				py_q <= pix_in.pixel_y;
				j_q  <= '0;
			end
			ST_MAP_RE: begin
				if (mode_q == MODE_JULIA) begin
					re_q   <= p_val;
					c_re_q <= julia_re_q;
				end else begin
					re_q   <= '0;
					c_re_q <= p_val;
				end
			end
			ST_MAP_IM: begin
				if (mode_q == MODE_JULIA) begin
					im_q   <= p_val;
					c_im_q <= julia_im_q;
				end else begin
					im_q   <= '0;
					c_im_q <= p_val;
				end
			end
			ST_CHECK: begin
				count_q <= j_q;
				esc_q   <= 1'b0;
			end
			ST_SQ_RE: begin
				sr_q <= sq;
			end
			ST_SQ_IM: begin
				si_q    <= sq;
				count_q <= j_q;
				esc_q   <= 1'b1;
			end
			ST_CROSS: begin
				cross_q <= sq;
			end
			ST_UPDATE: begin
				re_q <= upd_re;
				im_q <= upd_im;
				j_q  <= j_q + 1'b1;
			end
			default: begin
				j_q <= j_q;
			end
		endcase
	end

	// Result register, free to hold while the next item is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (res_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_x_q   <= px_q;
			out_y_q   <= py_q;
			out_cnt_q <= count_q;
			out_esc_q <= esc_q;
		end
	end

	assign res_out.valid      = out_valid_q;
	assign res_out.out_x      = out_x_q;
	assign res_out.out_y      = out_y_q;
	assign res_out.iter_count = out_cnt_q;
	assign res_out.escaped    = out_esc_q;

	// Checks
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		mul_req.start |-> !mul_rsp.busy && !mul_rsp.done)
		else $error("multiplier started while still working");

	a_done_owned: assert property (@(posedge clk) disable iff (!arst_n)
		mul_rsp.done |-> run_q)
		else $error("multiplier result with no request outstanding");

	a_out_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_out.valid) |-> $past(state_q == ST_FINISH))
		else $error("result shown without a finished item");

	a_accept_maps: assert property (@(posedge clk) disable iff (!arst_n)
		pix_in.valid && pix_in.ready |=> state_q == ST_MAP_RE)
		else $error("accepted item did not start mapping");

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// Escape-time fractal pixel: self-checking testbench
// Sends pixels through the valid/ready input channel and predicts each
// result with a fixed-point iteration kept in the bench. Register settings
// change only while the engine is idle. Input and result sides idle and
// stall at random, varying from one phase to the next.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import etf_pkg::*;

	localparam int QUIET_LIMIT   = 400000;
	localparam int RAND_PHASES   = 12;
	localparam int PHASE_PIXELS  = 150;
	localparam int SETTLE_CYCLES = 50;

	// Spare mode code, decoded as Mandelbrot
	localparam logic [1:0] MODE_SPARE = 2'd3;

	localparam longint PROD_CAP = 64'sd1 <<< 61;

	typedef struct packed {
		logic [PIX_W-1:0] x;
		logic [PIX_W-1:0] y;
	} pixel_t;

	typedef struct packed {
		logic [PIX_W-1:0]  x;
		logic [PIX_W-1:0]  y;
		logic [ITER_W-1:0] count;
		logic              escaped;
	} pix_result_t;

	typedef struct {
		logic [1:0]              mode;
		logic [ITER_W-1:0]       max_iter;
		logic [STEP_W-1:0]       step;
		logic signed [VAL_W-1:0] c_re;
		logic signed [VAL_W-1:0] c_im;
		logic signed [VAL_W-1:0] j_re;
		logic signed [VAL_W-1:0] j_im;
		logic [STEP_W-1:0]       bailout;
	} plane_cfg_t;

	logic clk = 1'b0;
	logic arst_n;

	etf_pix_if pix ();
	etf_res_if res ();
	etf_cfg_if cfg ();

	escape_time_fractal_pixel DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.pix_in  (pix),
		.res_out (res),
		.cfg     (cfg)
	);

	// Register copy seen by the predictor
	plane_cfg_t  plane;
	pixel_t      pixel_queue[$];
	pix_result_t expected_q[$];

	int send_idle_pct;
	int recv_stall_pct;
	int fail_count;
	int result_count;
	int escaped_count;
	int setting_count;
	int quiet_cycles;

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// Fixed-point predictor
	// ------------------------------------------------------------------
	function automatic longint clamp_plane(longint v);
		if (v > VAL_MAX64)
			return VAL_MAX64;
		if (v < VAL_MIN64)
			return VAL_MIN64;
		return v;
	endfunction

	function automatic longint abs_plane(longint v);
		return (v < 0) ? -v : v;
	endfunction

	// Product of two magnitudes, truncated by FRAC_BITS, capped
	function automatic longint mul_mag(longint a, longint b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		p = p >> FRAC_BITS;
		if (p > 128'(PROD_CAP))
			return PROD_CAP;
		return longint'(p[63:0]);
	endfunction

	// Signed product, truncated toward zero
	function automatic longint mul_signed(longint a, longint b);
		longint m;
		m = mul_mag(abs_plane(a), abs_plane(b));
		return ((a < 0) != (b < 0)) ? -m : m;
	endfunction

	function automatic pix_result_t predict_pixel(pixel_t p);
		longint      off_x, off_y, p_re, p_im;
		longint      z_re, z_im, k_re, k_im, sq_re, sq_im, cross_term;
		pix_result_t r;
		r.x       = p.x;
		r.y       = p.y;
		r.count   = plane.max_iter;
		r.escaped = 1'b0;
		off_x = longint'({54'd0, p.x}) - IMG_W / 2;
		off_y = longint'({54'd0, p.y}) - IMG_H / 2;
		p_re  = clamp_plane(off_x * longint'({17'd0, plane.step}) + longint'(plane.c_re));
		p_im  = clamp_plane(off_y * longint'({17'd0, plane.step}) - longint'(plane.c_im));
		if (plane.mode == MODE_JULIA) begin
			z_re = p_re;
			z_im = p_im;
			k_re = longint'(plane.j_re);
			k_im = longint'(plane.j_im);
		end else begin
			z_re = 0;
			z_im = 0;
			k_re = p_re;
			k_im = p_im;
		end
		for (int j = 0; j < plane.max_iter; j++) begin
			sq_re = mul_mag(abs_plane(z_re), abs_plane(z_re));
			sq_im = mul_mag(abs_plane(z_im), abs_plane(z_im));
			// escape test comes before the fold and the update
			if (sq_re + sq_im > longint'({17'd0, plane.bailout})) begin
				r.count   = ITER_W'(j);
				r.escaped = 1'b1;
				break;
			end
			if (plane.mode == MODE_SHIP) begin
				z_re = abs_plane(z_re);
				z_im = abs_plane(z_im);
			end
			cross_term = mul_signed(z_re, z_im);
			z_re  = clamp_plane(sq_re - sq_im + k_re);
			z_im  = clamp_plane(2 * cross_term + k_im);
		end
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Random helpers
	// ------------------------------------------------------------------
	// Signed plane value in [-2^bits, 2^bits)
	function automatic logic signed [VAL_W-1:0] rand_plane(int bits);
		longint r;
		r = longint'({$urandom, $urandom});
		r = r >>> (63 - bits);
		return r[VAL_W-1:0];
	endfunction

	function automatic logic [STEP_W-1:0] rand_wide();
		logic [63:0] t;
		t = {$urandom, $urandom};
		return t[STEP_W-1:0];
	endfunction

	function automatic plane_cfg_t default_setting();
		plane_cfg_t c;
		c.mode     = RST_MODE;
		c.max_iter = RST_MAX_ITER;
		c.step     = RST_STEP;
		c.c_re     = '0;
		c.c_im     = '0;
		c.j_re     = '0;
		c.j_im     = '0;
		c.bailout  = RST_BAILOUT;
		return c;
	endfunction

	function automatic plane_cfg_t random_setting();
		plane_cfg_t c;
		c = default_setting();
		c.mode     = ($urandom_range(9) == 0) ? MODE_SPARE : 2'($urandom_range(2));
		c.max_iter = ITER_W'($urandom_range(1, 32));
		case ($urandom_range(3))
			0: begin
				c.step = RST_STEP >> $urandom_range(0, 8);
			end
			1: begin
				c.step = RST_STEP >> $urandom_range(9, 20);
			end
			2: begin
				c.step = rand_wide();
			end
			default: begin
				c.step = STEP_W'($urandom_range(1, 4096));
			end
		endcase
		// mostly near the interesting region, now and then anywhere
		if ($urandom_range(7) == 0) begin
			c.c_re = rand_plane(47);
			c.c_im = rand_plane(47);
		end else begin
			c.c_re = rand_plane($urandom_range(40, 45));
			c.c_im = rand_plane($urandom_range(40, 45));
		end
		c.j_re = rand_plane(44);
		c.j_im = rand_plane(44);
		case ($urandom_range(7))
			0: begin
				c.bailout = rand_wide();
			end
			1: begin
				c.bailout = STEP_W'($urandom_range(0, 1 << 20));
			end
			default: begin
				c.bailout = RST_BAILOUT;
			end
		endcase
		return c;
	endfunction

	// ------------------------------------------------------------------
	// Register writes, phase control
	// ------------------------------------------------------------------
	task automatic write_reg(cfg_reg_t idx, logic [VAL_W-1:0] data);
		@(posedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= data;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		case (idx)
			REG_MODE:      plane.mode     = data[1:0];
			REG_MAX_ITER:  plane.max_iter = data[ITER_W-1:0];
			REG_STEP:      plane.step     = data[STEP_W-1:0];
			REG_CENTER_RE: plane.c_re     = data;
			REG_CENTER_IM: plane.c_im     = data;
			REG_JULIA_RE:  plane.j_re     = data;
			REG_JULIA_IM:  plane.j_im     = data;
			REG_BAILOUT:   plane.bailout  = data[STEP_W-1:0];
			default: ;
		endcase
	endtask

	task automatic apply_setting(plane_cfg_t c);
		write_reg(REG_MODE,      {46'd0, c.mode});
		write_reg(REG_MAX_ITER,  {36'd0, c.max_iter});
		write_reg(REG_STEP,      {1'b0, c.step});
		write_reg(REG_CENTER_RE, c.c_re);
		write_reg(REG_CENTER_IM, c.c_im);
		write_reg(REG_JULIA_RE,  c.j_re);
		write_reg(REG_JULIA_IM,  c.j_im);
		write_reg(REG_BAILOUT,   {1'b0, c.bailout});
		setting_count++;
		@(negedge clk);
	endtask

	task automatic queue_pixel(int x, int y);
		pixel_t p;
		p.x = PIX_W'(x);
		p.y = PIX_W'(y);
		pixel_queue.push_back(p);
	endtask

	// Hold off until every queued pixel has produced its result
	task automatic drain();
		do @(negedge clk); while (pixel_queue.size() != 0 || pix.valid ||
			expected_q.size() != 0);
	endtask

	task automatic set_idling(int phase);
		case (phase % 4)
			0: begin
				send_idle_pct  = 0;
				recv_stall_pct = 0;
			end
			1: begin
				send_idle_pct  = 55;
				recv_stall_pct = 0;
			end
			2: begin
				send_idle_pct  = 0;
				recv_stall_pct = 55;
			end
			default: begin
				send_idle_pct  = 32;
				recv_stall_pct = 32;
			end
		endcase
	endtask

	// ------------------------------------------------------------------
	// Pixel driver: predicts on acceptance, then offers the next item
	// ------------------------------------------------------------------
	always @(posedge clk) begin : drive_pixels
		pixel_t nxt;
		if (arst_n) begin
			if (pix.valid && pix.ready)
				expected_q.push_back(predict_pixel(pixel_t'({pix.pixel_x, pix.pixel_y})));
			if (!pix.valid || pix.ready) begin
				if (pixel_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					nxt = pixel_queue.pop_front();
					pix.valid   <= 1'b1;
					pix.pixel_x <= nxt.x;
					pix.pixel_y <= nxt.y;
				end else begin
					pix.valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Result monitor
	// ------------------------------------------------------------------
	task automatic check_field(string name, longint want, longint got);
		if (want != got) begin
			fail_count++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin : watch_results
		pix_result_t got, want;
		if (arst_n) begin
			if (res.valid && res.ready) begin
				got = {res.out_x, res.out_y, res.iter_count, res.escaped};
				result_count++;
				if (got.escaped)
					escaped_count++;
				if (expected_q.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected result, expected none, actual (%0d,%0d) count %0d",
						$time, got.x, got.y, got.count);
				end else begin
					want = expected_q.pop_front();
					check_field("out_x", want.x, got.x);
					check_field("out_y", want.y, got.y);
					check_field("iter_count", want.count, got.count);
					check_field("escaped", want.escaped, got.escaped);
				end
			end
			res.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// ------------------------------------------------------------------
	// Watchdog on handshake activity
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if ((pix.valid && pix.ready) || (res.valid && res.ready) ||
			    (cfg.valid && cfg.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no handshake for %0d cycles, %0d results outstanding",
					$time, quiet_cycles, expected_q.size());
				$display("status: fail");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	initial begin : stimulus
		plane_cfg_t c;
		arst_n         = 1'b0;
		pix.valid      = 1'b0;
		pix.pixel_x    = '0;
		pix.pixel_y    = '0;
		res.ready      = 1'b0;
		cfg.valid      = 1'b0;
		cfg.index      = REG_MODE;
		cfg.data       = '0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		fail_count     = 0;
		result_count   = 0;
		escaped_count  = 0;
		setting_count  = 0;
		quiet_cycles   = 0;
		plane          = default_setting();

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset values: corners, centre, edges
		queue_pixel(0, 0);
		queue_pixel(1023, 1023);
		queue_pixel(0, 1023);
		queue_pixel(1023, 0);
		queue_pixel(512, 512);
		queue_pixel(512, 0);
		queue_pixel(300, 600);
		drain();

		// Julia with a classic constant
		set_idling(1);
		c = default_setting();
		c.mode     = MODE_JULIA;
		c.max_iter = 12'd64;
		c.j_re     = -48'sd14073748835533;
		c.j_im     = 48'sd2744381022929;
		apply_setting(c);
		queue_pixel(512, 512);
		queue_pixel(600, 450);
		queue_pixel(0, 0);
		drain();

		// Burning ship, shifted centre
		set_idling(2);
		c = default_setting();
		c.mode     = MODE_SHIP;
		c.max_iter = 12'd40;
		c.c_re     = -48'sd8796093022208;
		c.c_im     = 48'sd8796093022208;
		apply_setting(c);
		queue_pixel(400, 400);
		queue_pixel(512, 430);
		queue_pixel(700, 300);
		drain();

		// Unused mode code falls back to Mandelbrot
		set_idling(3);
		c = default_setting();
		c.mode     = MODE_SPARE;
		c.max_iter = 12'd30;
		apply_setting(c);
		queue_pixel(450, 512);
		queue_pixel(1023, 512);
		drain();

		// No iterations at all
		set_idling(0);
		c = default_setting();
		c.max_iter = '0;
		apply_setting(c);
		queue_pixel(512, 512);
		drain();

		// Zero step: every pixel lands on the centre
		c = default_setting();
		c.step = '0;
		c.c_re = 48'sd4398046511104;
		c.c_im = -48'sd1759218604442;
		apply_setting(c);
		queue_pixel(0, 0);
		queue_pixel(1023, 1023);
		drain();

		// Largest step and centre: mapped coordinates saturate
		c = default_setting();
		c.max_iter = 12'd20;
		c.step     = '1;
		c.c_re     = 48'sh7FFF_FFFF_FFFF;
		c.c_im     = 48'sh7FFF_FFFF_FFFF;
		c.bailout  = '1;
		apply_setting(c);
		queue_pixel(1023, 1023);
		queue_pixel(0, 0);
		drain();

		// c just inside the widest bailout, so the next z overflows
		c.step = '0;
		c.c_re = 48'sd49258120924365;
		c.c_im = '0;
		apply_setting(c);
		queue_pixel(5, 5);
		drain();

		// Most negative centre with the smallest step
		c.step     = 47'd1;
		c.max_iter = 12'd5;
		c.c_re     = 48'sh8000_0000_0000;
		c.c_im     = 48'sh8000_0000_0000;
		apply_setting(c);
		queue_pixel(0, 1023);
		drain();

		// Zero bailout: only the origin survives
		c = default_setting();
		c.max_iter = 12'd10;
		c.bailout  = '0;
		apply_setting(c);
		queue_pixel(512, 512);
		queue_pixel(513, 512);
		drain();

		// Longest run: the origin never escapes
		c = default_setting();
		c.max_iter = 12'd4095;
		apply_setting(c);
		queue_pixel(512, 512);
		queue_pixel(100, 100);
		drain();

		// Random settings and pixels; idling pattern rotates per phase
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			set_idling(ph);
			apply_setting(random_setting());
			for (int i = 0; i < PHASE_PIXELS; i++) begin
				if ($urandom_range(3) == 0)
					queue_pixel($urandom_range(448, 575), $urandom_range(448, 575));
				else
					queue_pixel($urandom_range(1023), $urandom_range(1023));
			end
			drain();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("run covered %0d pixels over %0d register settings", result_count,
			setting_count + 1);
		$display("%0d pixels escaped, %0d ran to the iteration limit", escaped_count,
			result_count - escaped_count);
		if (expected_q.size() != 0)
			$display("%0t: %0d results never arrived", $time, expected_q.size());
		if (fail_count == 0 && expected_q.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
